### rtl/csd_pkg.sv
// csd_pkg: types and constants shared by the can signal decoder
`timescale 1ns / 1ps
package csd_pkg;

  localparam int IdW      = 11;
  localparam int DataW    = 64;
  localparam int StartW   = 6;
  localparam int LenW     = 7;
  localparam int ModeW    = 4;
  localparam int CfgW     = 32;
  localparam int CfgIdxW  = 3;
  localparam int IntW     = 33;
  localparam int FixW     = 48;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_MATCH_ID   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LSB_POS    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_FIELD_LEN  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MODE       = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SCALE      = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_OFFSET     = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_MIN_LIMIT  = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_MAX_LIMIT  = 3'd7;

  // mode bits
  localparam int MODE_SIGNED = 0;
  localparam int MODE_FIXED  = 1;

  // width codes in mode[3:2]
  localparam logic [1:0] WCODE_8  = 2'd0;
  localparam logic [1:0] WCODE_16 = 2'd1;
  localparam logic [1:0] WCODE_24 = 2'd2;
  localparam logic [1:0] WCODE_32 = 2'd3;

  localparam logic [LenW-1:0] MAX_LEN = 7'd64;

  // result kinds
  localparam logic KIND_INT   = 1'b0;
  localparam logic KIND_FIXED = 1'b1;

  typedef struct packed {
    logic [IdW-1:0]    match_id;
    logic [StartW-1:0] lsb_pos;
    logic [LenW-1:0]   field_len;
    logic [ModeW-1:0]  mode;
    logic [CfgW-1:0]   scale;
    logic [CfgW-1:0]   offset;
    logic [CfgW-1:0]   min_limit;
    logic [CfgW-1:0]   max_limit;
  } csd_cfg_t;

  localparam csd_cfg_t CFG_RESET = '{
    match_id:   11'd0,
    lsb_pos:    6'd0,
    field_len:  7'd8,
    mode:       4'd0,
    scale:      32'd65536,
    offset:     32'd0,
    min_limit:  32'd0,
    max_limit:  32'hFFFF_FFFF
  };

endpackage

### rtl/csd_if.sv
// csd_frame_if and csd_result_if: valid/ready channels of the decoder
`timescale 1ns / 1ps
interface csd_frame_if;
  import csd_pkg::*;
  logic             valid;
  logic             ready;
  logic [IdW-1:0]   frame_id;
  logic [DataW-1:0] payload;

  modport source (output valid, frame_id, payload, input ready);
  modport sink   (input valid, frame_id, payload, output ready);
endinterface

interface csd_result_if;
  import csd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [IntW-1:0] int_value;
  logic signed [FixW-1:0] fixed_value;
  logic                   out_kind;

  modport source (output valid, int_value, fixed_value, out_kind, input ready);
  modport sink   (input valid, int_value, fixed_value, out_kind, output ready);
endinterface

### rtl/can_signal_decoder.sv
// can_signal_decoder: six-stage pipeline that decodes one signal from a CAN frame
//
// Takes one frame per clock while the result side is not stalled and returns
// one word per matching frame. The stages are: field extraction, magnitude,
// split 48x32 multiply (a 32x32 and a 16x32 product), product sum and cap,
// signed offset add with saturation, integer conversion (or fixed pass-through)
// into the output register. Frames whose identifier differs from match_id
// leave no word. The pipeline only stops when the result side holds off, and
// then only the stages that are full stop. Registers are written through the
// plain write port by the user only while no frame is in flight; not enforced.
`timescale 1ns / 1ps
module can_signal_decoder
  import csd_pkg::*;
#(
  parameter int PAYLOAD_BITS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_wdata,
  csd_frame_if.sink          frame,
  csd_result_if.source       result
);

  localparam int NStg = 6;
  localparam logic [DataW-1:0] PayMask =
    (PAYLOAD_BITS >= DataW) ? {DataW{1'b1}} : ((DataW'(1) << PAYLOAD_BITS) - DataW'(1));

  csd_cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MATCH_ID:   cfg.match_id   <= cfg_wdata[IdW-1:0];
        REG_LSB_POS:    cfg.lsb_pos    <= cfg_wdata[StartW-1:0];
        REG_FIELD_LEN:  cfg.field_len  <= cfg_wdata[LenW-1:0];
        REG_MODE:       cfg.mode       <= cfg_wdata[ModeW-1:0];
        REG_SCALE:      cfg.scale      <= cfg_wdata;
        REG_OFFSET:     cfg.offset     <= cfg_wdata;
        REG_MIN_LIMIT:  cfg.min_limit  <= cfg_wdata;
        REG_MAX_LIMIT:  cfg.max_limit  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage control: a stage loads when empty or when the next one moves
  logic [NStg-1:0] vld;
  logic [NStg-1:0] adv;

  always_comb begin
    adv[NStg-1] = !vld[NStg-1] || result.ready;
    for (int k = NStg-2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign frame.ready = adv[0];

  logic hit;
  assign hit = frame.valid && (frame.frame_id == cfg.match_id);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= hit;
      end
      for (int k = 1; k < NStg; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage 1: field extraction and sign extension
  logic [DataW-1:0] shifted;
  logic [LenW-1:0]  len;
  logic [LenW-1:0]  len_m1;
  logic [DataW-1:0] fmask;
  logic [DataW-1:0] field;
  logic             fneg;
  logic [DataW-1:0] s1_raw;
  logic             s1_neg;

  always_comb begin
    shifted = (frame.payload & PayMask) >> cfg.lsb_pos;
    len     = (cfg.field_len > MAX_LEN) ? MAX_LEN : cfg.field_len;
    len_m1  = len - LenW'(1);
    fmask   = (len >= MAX_LEN) ? {DataW{1'b1}} : ((DataW'(1) << len) - DataW'(1));
    field   = shifted & fmask;
    fneg    = cfg.mode[MODE_SIGNED] && (len != '0) && field[len_m1[StartW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_raw <= fneg ? (field | ~fmask) : field;
      s1_neg <= fneg;
    end
  end

  // stage 2: magnitudes and product sign
  logic [DataW-1:0] s2_mag;
  logic [CfgW-1:0]  s2_smag;
  logic             s2_neg;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_mag  <= s1_neg ? (~s1_raw + DataW'(1)) : s1_raw;
      s2_smag <= cfg.scale[CfgW-1] ? (~cfg.scale + CfgW'(1)) : cfg.scale;
      s2_neg  <= s1_neg ^ cfg.scale[CfgW-1];
    end
  end

  // stage 3: two partial products; bits above 47 only flag overflow
  logic [63:0] s3_plo;
  logic [47:0] s3_phi;
  logic        s3_big;
  logic        s3_neg;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_plo <= 64'(s2_mag[31:0]) * 64'(s2_smag);
      s3_phi <= 48'(s2_mag[47:32]) * 48'(s2_smag);
      s3_big <= (|s2_mag[63:48]) && (|s2_smag);
      s3_neg <= s2_neg;
    end
  end

  // stage 4: sum and cap at 2^48, already past the saturation range
  logic [79:0] psum;
  logic [48:0] s4_prod;
  logic        s4_neg;

  assign psum = {16'd0, s3_plo} + {s3_phi, 32'd0};

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s4_prod <= (s3_big || (|psum[79:48])) ? {1'b1, 48'd0} : {1'b0, psum[47:0]};
      s4_neg  <= s3_neg;
    end
  end

  // stage 5: apply sign, add offset, saturate to Q32.16
  logic [50:0]            sprod;
  logic [50:0]            qsum;
  logic signed [FixW-1:0] qsat;
  logic signed [FixW-1:0] s5_q;

  always_comb begin
    sprod = s4_neg ? (~{2'b00, s4_prod} + 51'd1) : {2'b00, s4_prod};
    qsum  = sprod + {{19{cfg.offset[31]}}, cfg.offset};
    if (!qsum[50] && (|qsum[49:47])) begin
      qsat = {1'b0, {(FixW-1){1'b1}}};
    end else if (qsum[50] && !(&qsum[49:47])) begin
      qsat = {1'b1, {(FixW-1){1'b0}}};
    end else begin
      qsat = qsum[FixW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s5_q <= qsat;
    end
  end

  // stage 6: output register
  logic signed [IntW-1:0] conv_int;

  csd_int_conv u_int_conv (
    .cfg       (cfg),
    .q         (s5_q),
    .int_value (conv_int)
  );

  logic signed [IntW-1:0] out_int;
  logic signed [FixW-1:0] out_fix;
  logic                   out_kind;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      if (cfg.mode[MODE_FIXED]) begin
        out_int  <= '0;
        out_fix  <= s5_q;
        out_kind <= KIND_FIXED;
      end else begin
        out_int  <= conv_int;
        out_fix  <= '0;
        out_kind <= KIND_INT;
      end
    end
  end

  assign result.valid       = vld[NStg-1];
  assign result.int_value   = out_int;
  assign result.fixed_value = out_fix;
  assign result.out_kind    = out_kind;

endmodule

### rtl/csd_int_conv.sv
// csd_int_conv: Q32.16 to integer truncation, clamp in unsigned mode and width wrap
`timescale 1ns / 1ps
module csd_int_conv
  import csd_pkg::*;
(
  input  csd_cfg_t               cfg,
  input  logic signed [FixW-1:0] q,
  output logic signed [IntW-1:0] int_value
);

  logic [FixW:0]   qa;
  logic [IntW-1:0] ip;
  logic [IntW-1:0] cl;
  logic            sgn;

  always_comb begin
    sgn = cfg.mode[MODE_SIGNED];
    // round toward zero: bias negatives before the arithmetic shift
    qa  = {q[FixW-1], q} + (q[FixW-1] ? (FixW+1)'(16'hFFFF) : '0);
    ip  = qa[FixW:16];
    cl  = ip;
    if (!sgn) begin
      if ($signed(ip) > $signed({1'b0, cfg.max_limit})) begin
        cl = {1'b0, cfg.max_limit};
      end else if ($signed(ip) < $signed({1'b0, cfg.min_limit})) begin
        cl = {1'b0, cfg.min_limit};
      end
    end
    case (cfg.mode[3:2])
      WCODE_8:  int_value = {{25{sgn & cl[7]}}, cl[7:0]};
      WCODE_16: int_value = {{17{sgn & cl[15]}}, cl[15:0]};
      WCODE_24: int_value = {{9{sgn & cl[23]}}, cl[23:0]};
      WCODE_32: int_value = {sgn & cl[31], cl[31:0]};
      default:  int_value = '0;
    endcase
  end

endmodule

### rtl/csd_checker.sv
// csd_checker: port-level assertions for the decoder, bound to the top level
`timescale 1ns / 1ps
module csd_checker
  import csd_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   frame_ready,
  input logic                   result_valid,
  input logic                   result_ready,
  input logic signed [IntW-1:0] int_value,
  input logic signed [FixW-1:0] fixed_value,
  input logic                   out_kind
);

  // a stalled word keeps its contents
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(int_value) && $stable(fixed_value) && $stable(out_kind))
    else $error("result word changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // the unused field of a word is zero
  a_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (out_kind == KIND_FIXED) ? (int_value == '0) : (fixed_value == '0))
    else $error("unused result field not zero");

  // frames are only held off when the whole pipe is backed up
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !frame_ready |-> result_valid && !result_ready)
    else $error("frame side stalled without result stall");

endmodule

bind can_signal_decoder csd_checker u_csd_checker (
  .clk          (clk),
  .rst          (rst),
  .frame_ready  (frame.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .int_value    (result.int_value),
  .fixed_value  (result.fixed_value),
  .out_kind     (result.out_kind)
);
